// ===== rtl/lidtrk2_pkg.sv =====
package lidtrk2_pkg;

  localparam int CAPACITY = 256;
  // wide enough to hold CAPACITY itself
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SH_W     = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_START  = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SLOT_UNSET   = 2'd0,
    SLOT_CLEARED = 2'd1,
    SLOT_SEEN    = 2'd2
  } slot_t;

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_INSERT,
    CELL_START,
    CELL_CHECK,
    CELL_END,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     parity;
  } cell_ctl_t;

  // counts are reported modulo 512
  function automatic logic [8:0] count9(logic [CNT_W-1:0] v);
    logic [CNT_W+8:0] w;
    w = {9'd0, v};
    return w[8:0];
  endfunction

endpackage

// ===== rtl/lidtrk2_cell.sv =====
module lidtrk2_cell
  import lidtrk2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_ctl_t   ctl,
  input  logic        alloc,
  input  logic [31:0] key,
  input  logic [31:0] cur_cycle,
  input  logic [31:0] age_limit,
  input  logic        rm_in,
  output logic        rm_out,
  output logic        match,
  output logic        valid
);

  logic        valid_r;
  logic [31:0] key_r;
  logic [31:0] birth_r;
  logic        seen_r;
  slot_t       even_r;
  slot_t       odd_r;
  logic        rm_r;

  logic [31:0] age;
  logic        remove;

  assign match  = valid_r && (key_r == key);
  assign valid  = valid_r;
  assign rm_out = rm_r;

  // age wraps at 32 bits
  assign age    = cur_cycle - birth_r;
  assign remove = valid_r && (even_r == SLOT_CLEARED) && (odd_r == SLOT_CLEARED) &&
                  (seen_r || (age > age_limit));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_INSERT: if (alloc) valid_r <= 1'b1;
        CELL_END:    if (remove) valid_r <= 1'b0;
        default:     valid_r <= valid_r;
      endcase
    end

    case (ctl.op)
      CELL_INSERT: begin
        if (alloc) begin
          key_r   <= key;
          birth_r <= cur_cycle;
          seen_r  <= 1'b0;
          even_r  <= SLOT_UNSET;
          odd_r   <= SLOT_UNSET;
        end
      end
      CELL_START: begin
        if (valid_r) begin
          if (ctl.parity) odd_r <= SLOT_CLEARED;
          else            even_r <= SLOT_CLEARED;
        end
      end
      CELL_CHECK: begin
        if (match) begin
          seen_r <= 1'b1;
          if (ctl.parity) odd_r <= SLOT_SEEN;
          else            even_r <= SLOT_SEEN;
        end
      end
      CELL_END:   rm_r <= remove;
      CELL_SHIFT: rm_r <= rm_in;
      default: ;
    endcase
  end

endmodule

// ===== rtl/launch_id_tracker_two_slot_core.sv =====
// Tracks up to CAPACITY 32-bit IDs in a row of entry cells that compare the key in parallel.
// Check and cycle start pass through a transfer step and an evaluate step; insert adds a write
// step, which writes the lowest free cell picked from the valid vector. In cycle end each cell
// flags its removal and the flags are shifted along the chain one cell per cycle and counted
// where it ends. A stalled result waits in a done state until the output register is free. Input is
// taken only between items; the result sits in an output register so the next item can start
// while it waits. age_limit may be written on the cfg port whenever the block is idle.
module launch_id_tracker_two_slot_core
  import lidtrk2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_correlation_id,
  input  logic [31:0] in_cycle_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [1:0]  out_status,
  output logic [8:0]  out_entry_count,
  output logic [8:0]  out_removed_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WRITE,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic [31:0]         key_r;
  logic [31:0]         cyc_r;
  logic [31:0]         cur_cycle_r, cur_cycle_nxt;
  logic [31:0]         age_limit_r;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [CNT_W-1:0]    rm_cnt_r, rm_cnt_nxt;
  logic [SH_W-1:0]     sh_cnt_r, sh_cnt_nxt;
  logic [CAPACITY-1:0] alloc_r, alloc_nxt;
  logic                res_hit_r, res_hit_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [8:0]          res_removed_r, res_removed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [8:0]          out_entry_r, out_entry_nxt;
  logic [8:0]          out_removed_r, out_removed_nxt;

  cell_ctl_t           ctl;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] free_vec;
  logic [CAPACITY-1:0] lowest_free;
  logic [CAPACITY:0]   rm_link;
  logic                any_match;
  logic                full;
  logic                out_free;
  logic                fin;
  logic                fin_hit;
  status_t             fin_status;
  logic [8:0]          fin_removed;
  logic [CNT_W-1:0]    rm_total;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_entry_r;
  assign out_removed_count = out_removed_r;

  assign any_match   = |match_vec;
  assign full        = (occ_r == CNT_W'(CAPACITY));
  assign free_vec    = ~valid_vec;
  // isolate lowest set bit
  assign lowest_free = free_vec & (~free_vec + CAPACITY'(1));
  assign out_free    = !out_valid_r || out_ready;
  assign rm_link[0]  = 1'b0;
  assign rm_total    = rm_cnt_r + CNT_W'(rm_link[CAPACITY]);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lidtrk2_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .alloc     (alloc_r[g]),
      .key       (key_r),
      .cur_cycle (cur_cycle_r),
      .age_limit (age_limit_r),
      .rm_in     (rm_link[g]),
      .rm_out    (rm_link[g+1]),
      .match     (match_vec[g]),
      .valid     (valid_vec[g])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    cur_cycle_nxt   = cur_cycle_r;
    occ_nxt         = occ_r;
    rm_cnt_nxt      = rm_cnt_r;
    sh_cnt_nxt      = sh_cnt_r;
    alloc_nxt       = alloc_r;
    res_hit_nxt     = res_hit_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_hit_nxt     = out_hit_r;
    out_status_nxt  = out_status_r;
    out_entry_nxt   = out_entry_r;
    out_removed_nxt = out_removed_r;
    ctl.op          = CELL_IDLE;
    ctl.parity      = cyc_r[0];
    fin             = 1'b0;
    fin_hit         = 1'b0;
    fin_status      = ST_OK;
    fin_removed     = 9'd0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        case (cmd_r)
          CMD_INSERT: begin
            res_hit_nxt = any_match;
            if (any_match) begin
              res_status_nxt = ST_PRESENT;
              alloc_nxt      = '0;
            end else if (full) begin
              res_status_nxt = ST_FULL;
              alloc_nxt      = '0;
            end else begin
              res_status_nxt = ST_OK;
              alloc_nxt      = lowest_free;
              occ_nxt        = occ_r + CNT_W'(1);
            end
            state_nxt = S_WRITE;
          end
          CMD_START: begin
            ctl.op        = CELL_START;
            cur_cycle_nxt = cyc_r;
            fin           = 1'b1;
          end
          CMD_CHECK: begin
            ctl.op  = CELL_CHECK;
            fin     = 1'b1;
            fin_hit = any_match;
          end
          default: begin
            ctl.op     = CELL_END;
            rm_cnt_nxt = '0;
            sh_cnt_nxt = '0;
            state_nxt  = S_SHIFT;
          end
        endcase
      end
      S_WRITE: begin
        ctl.op     = CELL_INSERT;
        alloc_nxt  = '0;
        fin        = 1'b1;
        fin_hit    = res_hit_r;
        fin_status = res_status_r;
      end
      S_SHIFT: begin
        ctl.op     = CELL_SHIFT;
        rm_cnt_nxt = rm_total;
        sh_cnt_nxt = sh_cnt_r + SH_W'(1);
        if (sh_cnt_r == SH_W'(CAPACITY - 1)) begin
          occ_nxt     = occ_r - rm_total;
          fin         = 1'b1;
          fin_removed = count9(rm_total);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = res_hit_r;
          out_status_nxt  = res_status_r;
          out_entry_nxt   = count9(occ_r);
          out_removed_nxt = res_removed_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_nxt   = 1'b1;
        out_hit_nxt     = fin_hit;
        out_status_nxt  = fin_status;
        out_entry_nxt   = count9(occ_nxt);
        out_removed_nxt = fin_removed;
        state_nxt       = S_IDLE;
      end else begin
        res_hit_nxt     = fin_hit;
        res_status_nxt  = fin_status;
        res_removed_nxt = fin_removed;
        state_nxt       = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_cycle_r <= '0;
      occ_r       <= '0;
      age_limit_r <= 32'd100;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_cycle_r <= cur_cycle_nxt;
      occ_r       <= occ_nxt;
      alloc_r     <= alloc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) age_limit_r <= cfg_data;
    end

    if (in_valid && in_ready) begin
      cmd_r <= cmd_t'(in_command);
      key_r <= in_correlation_id;
      cyc_r <= in_cycle_number;
    end
    rm_cnt_r      <= rm_cnt_nxt;
    sh_cnt_r      <= sh_cnt_nxt;
    res_hit_r     <= res_hit_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    out_hit_r     <= out_hit_nxt;
    out_status_r  <= out_status_nxt;
    out_entry_r   <= out_entry_nxt;
    out_removed_r <= out_removed_nxt;
  end

  // keys are unique, so no more than one cell can match
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one cell holds the key");

  a_alloc_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(alloc_r))
    else $error("insert targets more than one cell");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_occ_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(valid_vec) == int'(occ_r)))
    else $error("occupancy out of step with valid cells");

endmodule

// ===== bench/launch_id_tracker_two_slot_core_test.sv =====
`timescale 1ns / 1ps

module launch_id_tracker_two_slot_core_test
  import lidtrk2_pkg::*;
();

  typedef struct packed {
    logic       hit;
    status_t    status;
    logic [8:0] entry_count;
    logic [8:0] removed_count;
  } tracker_result_t;

  localparam int QUIET_LIMIT    = 4000;
  localparam int AGE_LIMIT_INIT = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_INSERT;
  logic [31:0] in_correlation_id = '0;
  logic [31:0] in_cycle_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_hit;
  logic [1:0]  out_status;
  logic [8:0]  out_entry_count;
  logic [8:0]  out_removed_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // predictor copy of the tracking table
  logic        ent_valid [CAPACITY];
  logic [31:0] ent_key   [CAPACITY];
  logic [31:0] ent_birth [CAPACITY];
  logic        ent_seen  [CAPACITY];
  slot_t       ent_slot  [CAPACITY][2];
  logic [31:0] cur_cycle;
  int          held;
  logic [31:0] age_limit;

  tracker_result_t results_due[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  launch_id_tracker_two_slot_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_correlation_id (in_correlation_id),
    .in_cycle_number   (in_cycle_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .out_removed_count (out_removed_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int find_entry(logic [31:0] key);
    for (int i = 0; i < CAPACITY; i++) begin
      if (ent_valid[i] && ent_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic tracker_result_t predict_tracker_result(cmd_t cmd, logic [31:0] key,
                                                              logic [31:0] cyc);
    tracker_result_t r;
    int idx;
    int removed;
    logic [31:0] age;
    r = '0;
    removed = 0;
    case (cmd)
      CMD_INSERT: begin
        idx = find_entry(key);
        if (idx >= 0) begin
          r.hit = 1'b1;
          r.status = ST_PRESENT;
        end else if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          idx = 0;
          while (ent_valid[idx]) idx++;
          ent_valid[idx] = 1'b1;
          ent_key[idx] = key;
          ent_birth[idx] = cur_cycle;
          ent_seen[idx] = 1'b0;
          ent_slot[idx][0] = SLOT_UNSET;
          ent_slot[idx][1] = SLOT_UNSET;
          held++;
        end
      end
      CMD_START: begin
        cur_cycle = cyc;
        for (int i = 0; i < CAPACITY; i++) begin
          if (ent_valid[i]) ent_slot[i][cyc[0]] = SLOT_CLEARED;
        end
      end
      CMD_CHECK: begin
        idx = find_entry(key);
        if (idx >= 0) begin
          ent_slot[idx][cyc[0]] = SLOT_SEEN;
          ent_seen[idx] = 1'b1;
          r.hit = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (ent_valid[i] && ent_slot[i][0] == SLOT_CLEARED &&
              ent_slot[i][1] == SLOT_CLEARED) begin
            age = cur_cycle - ent_birth[i];
            if (ent_seen[i] || age > age_limit) begin
              ent_valid[i] = 1'b0;
              held--;
              removed++;
            end
          end
        end
      end
    endcase
    r.entry_count = 9'(held);
    r.removed_count = 9'(removed);
    return r;
  endfunction

  initial begin
    for (int i = 0; i < CAPACITY; i++) ent_valid[i] = 1'b0;
    cur_cycle = '0;
    held = 0;
    age_limit = AGE_LIMIT_INIT;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin : track_monitor
    tracker_result_t exp_r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) age_limit = cfg_data;
      if (in_valid && in_ready) begin
        results_due.push_back(predict_tracker_result(cmd_t'(in_command), in_correlation_id,
                                                     in_cycle_number));
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          exp_r = results_due.pop_front();
          if (out_hit !== exp_r.hit) begin
            $error("hit: expected %0d, got %0d", exp_r.hit, out_hit);
            fail_count++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            fail_count++;
          end
          if (out_entry_count !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.entry_count, out_entry_count);
            fail_count++;
          end
          if (out_removed_count !== exp_r.removed_count) begin
            $error("removed_count: expected %0d, got %0d", exp_r.removed_count,
                   out_removed_count);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** launch_id_tracker_two_slot_core: FAILED **");
    $finish;
  end

  task automatic send_item(cmd_t cmd, logic [31:0] key, logic [31:0] cyc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_correlation_id <= key;
    in_cycle_number <= cyc;
    do @(posedge clk); while (!in_ready);
  endtask

  // sampled on the falling edge so the monitor has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_age_limit(logic [31:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_item(CMD_END, 32'h0, 32'h0);
    send_item(CMD_CHECK, 32'h0, 32'h0);
    send_item(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_CHECK, 32'hA5A5_A5A5, 32'h2);
    send_item(CMD_START, 32'h5A5A_5A5A, 32'h0);
    send_item(CMD_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // seen entry goes once both slots are cleared
    send_item(CMD_START, 32'h0, 32'h1);
    send_item(CMD_END, 32'h0, 32'h0);
    // age wraps past zero: 102 - 0xffffffff = 103
    send_item(CMD_START, 32'h0, 32'd102);
    send_item(CMD_END, 32'h0, 32'h0);
    send_item(CMD_INSERT, 32'h1234_5678, 32'h0);
    send_item(CMD_CHECK, 32'h1234_5678, 32'd7);
    send_item(CMD_CHECK, 32'h1234_5678, 32'd8);
  endtask

  task automatic test_table_full();
    logic [31:0] base;
    logic [31:0] cyc;
    base = $urandom;
    cyc = $urandom;
    write_age_limit(32'h0);
    send_item(CMD_START, $urandom, cyc);
    for (int i = 0; i < CAPACITY + 3; i++) send_item(CMD_INSERT, base + i, $urandom);
    send_item(CMD_INSERT, base, $urandom);
    send_item(CMD_CHECK, base + 5, cyc);
    // every entry is at least one cycle old, so a zero limit empties the table
    send_item(CMD_START, $urandom, cyc + 1);
    send_item(CMD_START, $urandom, cyc + 2);
    send_item(CMD_END, $urandom, $urandom);
  endtask

  task automatic test_random_traffic(int n_items);
    logic [31:0] keys [24];
    logic [31:0] cyc;
    logic [31:0] chk_cyc;
    int sent;
    int n_ops;
    foreach (keys[i]) keys[i] = $urandom;
    cyc = $urandom;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(cmd_t'(2'($urandom_range(3))), $urandom, $urandom);
        sent++;
      end else begin
        if ($urandom_range(7) == 0) cyc = cyc + $urandom_range(50, 300);
        else cyc = cyc + 1;
        send_item(CMD_START, $urandom, cyc);
        n_ops = $urandom_range(2, 10);
        repeat (n_ops) begin
          chk_cyc = ($urandom_range(4) == 0) ? cyc + 1 : cyc;
          if ($urandom_range(9) < 4)
            send_item(CMD_INSERT, keys[$urandom_range(23)], $urandom);
          else
            send_item(CMD_CHECK, keys[$urandom_range(23)], chk_cyc);
        end
        send_item(CMD_END, $urandom, $urandom);
        sent += n_ops + 2;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 87;
    test_directed_cases();
    write_age_limit(32'($urandom_range(1, 8)));
    test_random_traffic(250);

    send_idle_pct = 87;
    recv_idle_pct = 34;
    write_age_limit(32'hFFFF_FFFF);
    test_random_traffic(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_table_full();
    write_age_limit($urandom);
    test_random_traffic(120);
    write_age_limit(32'd100);
    test_random_traffic(120);

    drain_results();
    repeat (CAPACITY + 8) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** launch_id_tracker_two_slot_core: PASSED **");
    end else begin
      $display("** launch_id_tracker_two_slot_core: FAILED **");
    end
    $finish;
  end

endmodule
